// ===== rtl/core/evt_pkg.sv =====
// Shared types, constants and table functions of the Euler vertex transform.
// Used by evt_trig and euler_vertex_transform; depends on nothing else.
package evt_pkg;

	localparam int COORD_W        = 32;
	localparam int STREAM_W       = 3 * COORD_W;
	localparam int SCALE_W        = 24;
	localparam int CFG_ADDR_W     = 3;
	localparam int CFG_DATA_W     = 32;
	localparam int DEF_ANGLE_BITS = 12;
	localparam int DEF_FRAC_BITS  = 16;

	localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

	// Register indexes of the configuration port.
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_YAW,
		REG_PITCH,
		REG_ROLL,
		REG_SCALE,
		REG_OFFSET_X,
		REG_OFFSET_Y,
		REG_OFFSET_Z
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ANG_YAW,
		ANG_PITCH,
		ANG_ROLL
	} angle_sel_t;

	// Load request for the sine/cosine coefficient registers.
	typedef struct packed {
		logic       load;
		angle_sel_t sel;
	} trig_load_t;

	localparam logic [63:0] Q62_ONE     = 64'h4000000000000000;
	localparam logic [63:0] Q62_HALF_PI = 64'h6487ED5110B4611A;

	// (a * b) >> 62 for unsigned Q2.62 values.
	function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// Unsigned quotient by restoring shift and subtract; only used while the
	// sine table is built, so it never becomes logic.
	function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] part;
		logic [63:0] quo;
		part = '0;
		quo  = '0;
		for (int i = 63; i >= 0; i--) begin
			part = {part[63:0], num[i]};
			if (part >= {1'b0, den}) begin
				part   = part - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Taylor series of sine or cosine for 0 <= t <= pi/4, Q2.62.
	function automatic logic [63:0] q62_series(input logic [63:0] t, input logic want_cos);
		logic [63:0] t2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] n;
		t2   = q62_mul(t, t);
		term = want_cos ? Q62_ONE : t;
		sum  = term;
		n    = want_cos ? 64'd0 : 64'd1;
		for (int k = 0; k < 12; k++) begin
			term = div_u64(q62_mul(term, t2), (n + 64'd1) * (n + 64'd2));
			n    = n + 64'd2;
			if (k % 2 == 1)
				sum = sum + term;
			else
				sum = sum - term;
		end
		return sum;
	endfunction

	// Quarter-wave entry m: round(2^frac_bits * sin(pi/2 * m / quarter)),
	// for 0 <= m <= quarter, quarter = 2^(angle_bits-2).
	function automatic logic [63:0] quarter_sine(input int unsigned m,
			input int unsigned angle_bits, input int unsigned frac_bits);
		logic [63:0] quarter;
		logic [63:0] mm;
		logic        use_cos;
		logic [63:0] v;
		quarter = 64'd1 << (angle_bits - 2);
		mm      = 64'(m);
		use_cos = 1'b0;
		if (2 * mm > quarter) begin
			mm      = quarter - mm;
			use_cos = 1'b1;
		end
		v = q62_series(q62_mul(Q62_HALF_PI, mm << (62 - (angle_bits - 2))), use_cos);
		v = (v + (64'd1 << (61 - frac_bits))) >> (62 - frac_bits);
		return v;
	endfunction

endpackage

// ===== rtl/core/evt_trig.sv =====
// Sine/cosine coefficient unit: quarter-wave ROM and the six rotation coefficients.
// Depends on evt_pkg for the table function and the load request type.
module evt_trig import evt_pkg::*; #(
	parameter int ANGLE_BITS = DEF_ANGLE_BITS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  trig_load_t                    ld,
	input  logic        [ANGLE_BITS-1:0]  angle,
	output logic signed [FRAC_BITS+1:0]   yaw_cos,
	output logic signed [FRAC_BITS+1:0]   yaw_sin,
	output logic signed [FRAC_BITS+1:0]   pitch_cos,
	output logic signed [FRAC_BITS+1:0]   pitch_sin,
	output logic signed [FRAC_BITS+1:0]   roll_cos,
	output logic signed [FRAC_BITS+1:0]   roll_sin
);

	localparam int QUARTER = 2 ** (ANGLE_BITS - 2);
	localparam int DEPTH   = QUARTER + 1;
	localparam int AW      = ANGLE_BITS - 1;
	localparam int MW      = FRAC_BITS + 1;
	localparam int CW      = FRAC_BITS + 2;

	typedef logic [MW-1:0] word_t;
	typedef word_t rom_t [DEPTH];

	function automatic rom_t build_rom();
		rom_t        t;
		logic [63:0] v;
		for (int m = 0; m < DEPTH; m++) begin
			v    = quarter_sine(m, ANGLE_BITS, FRAC_BITS);
			t[m] = v[MW-1:0];
		end
		return t;
	endfunction

	localparam rom_t SIN_ROM = build_rom();

	function automatic logic signed [CW-1:0] apply_sign(input logic neg, input word_t mag);
		logic signed [CW-1:0] v;
		v = $signed({1'b0, mag});
		return neg ? -v : v;
	endfunction

	logic [1:0]            quad_sin;
	logic [1:0]            quad_cos;
	logic [ANGLE_BITS-3:0] rem;
	logic [AW-1:0]         addr_sin;
	logic [AW-1:0]         addr_cos;

	word_t yaw_cos_q, yaw_sin_q, pitch_cos_q, pitch_sin_q, roll_cos_q, roll_sin_q;
	logic  yaw_cos_neg_q, yaw_sin_neg_q, pitch_cos_neg_q, pitch_sin_neg_q;
	logic  roll_cos_neg_q, roll_sin_neg_q;

	// Cosine is the sine a quarter turn later; odd quadrants read the table backwards.
	always_comb begin
		quad_sin = angle[ANGLE_BITS-1 -: 2];
		quad_cos = quad_sin + 2'd1;
		rem      = angle[ANGLE_BITS-3:0];
		addr_sin = quad_sin[0] ? (AW'(QUARTER) - {1'b0, rem}) : {1'b0, rem};
		addr_cos = quad_cos[0] ? (AW'(QUARTER) - {1'b0, rem}) : {1'b0, rem};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_cos_q       <= MW'(QUARTER * 0 + (1 << FRAC_BITS));
			yaw_sin_q       <= '0;
			pitch_cos_q     <= MW'(1 << FRAC_BITS);
			pitch_sin_q     <= '0;
			roll_cos_q      <= MW'(1 << FRAC_BITS);
			roll_sin_q      <= '0;
			yaw_cos_neg_q   <= 1'b0;
			yaw_sin_neg_q   <= 1'b0;
			pitch_cos_neg_q <= 1'b0;
			pitch_sin_neg_q <= 1'b0;
			roll_cos_neg_q  <= 1'b0;
			roll_sin_neg_q  <= 1'b0;
		end else if (ld.load) begin
			unique case (ld.sel)
				ANG_YAW: begin
					yaw_cos_q     <= SIN_ROM[addr_cos];
					yaw_sin_q     <= SIN_ROM[addr_sin];
					yaw_cos_neg_q <= quad_cos[1];
					yaw_sin_neg_q <= quad_sin[1];
				end
				ANG_PITCH: begin
					pitch_cos_q     <= SIN_ROM[addr_cos];
					pitch_sin_q     <= SIN_ROM[addr_sin];
					pitch_cos_neg_q <= quad_cos[1];
					pitch_sin_neg_q <= quad_sin[1];
				end
				ANG_ROLL: begin
					roll_cos_q     <= SIN_ROM[addr_cos];
					roll_sin_q     <= SIN_ROM[addr_sin];
					roll_cos_neg_q <= quad_cos[1];
					roll_sin_neg_q <= quad_sin[1];
				end
				default: begin
				end
			endcase
		end
	end

	assign yaw_cos   = apply_sign(yaw_cos_neg_q, yaw_cos_q);
	assign yaw_sin   = apply_sign(yaw_sin_neg_q, yaw_sin_q);
	assign pitch_cos = apply_sign(pitch_cos_neg_q, pitch_cos_q);
	assign pitch_sin = apply_sign(pitch_sin_neg_q, pitch_sin_q);
	assign roll_cos  = apply_sign(roll_cos_neg_q, roll_cos_q);
	assign roll_sin  = apply_sign(roll_sin_neg_q, roll_sin_q);

endmodule

// ===== rtl/core/euler_vertex_transform.sv =====
// Top level of the Euler vertex transform: configuration registers and the
// eight-stage rotate, scale and offset pipeline. Depends on evt_pkg and evt_trig.

// The block takes one vertex beat per clock and returns one placed vertex beat
// for each, in order, as long as the output side does not stall; the result is
// taken from the output register of stage eight. The rate of one beat per clock
// is set by the pipeline itself: each
// of the eight stages holds either one bank of multipliers or one bank of adders.
// Stages one to six rotate by roll, pitch and yaw (a multiply stage followed by a
// floor-and-add stage for each turn), stage seven multiplies by the scale and
// stage eight adds the offset and saturates into the output register. Each stage
// advances on its own when the next one is empty or moving, so bubbles close up
// and a waiting result does not block new input while earlier stages have room.
// Sine and cosine come from a quarter-wave table of 2^(ANGLE_BITS-2)+1 entries
// that is read once, at the clock edge of an angle write; the coefficients are
// therefore ready for the very next beat.
module euler_vertex_transform import evt_pkg::*; #(
	parameter int ANGLE_BITS = DEF_ANGLE_BITS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write port.
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// Vertex input stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [STREAM_W-1:0]   s_tdata,   // local_x [31:0], local_y [63:32], local_z [95:64]
	// Placed vertex output stream.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [STREAM_W-1:0]   m_tdata    // world_x [31:0], world_y [63:32], world_z [95:64]
);

	localparam int W    = COORD_W;
	localparam int CW   = FRAC_BITS + 2;       // signed coefficient, magnitude up to 1.0
	localparam int P1W  = W + CW;
	localparam int XW   = W + 2;               // x, y after roll
	localparam int P3AW = XW + CW;
	localparam int P3BW = W + CW;
	localparam int Y2W  = XW + 2;              // y2, z2 after pitch
	localparam int P5AW = XW + CW;
	localparam int P5BW = Y2W + CW;
	localparam int VW   = Y2W + 2;             // x3, z3 after yaw
	localparam int P7W  = VW + SCALE_W + 1;
	localparam int FW   = P7W - FRAC_BITS;     // scaled value after floor
	localparam int SW   = ((FW > W) ? FW : W) + 1;

	// Saturate a wide signed sum to the 32-bit output range.
	function automatic logic [W-1:0] sat_w(input logic signed [SW-1:0] v);
		logic [SW-W:0] hi;
		hi = v[SW-1:W-1];
		if ((hi == '0) || (hi == '1))
			return v[W-1:0];
		return v[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
	endfunction

	// ---------------------------------------------------------------- configuration
	logic        [SCALE_W-1:0] scale_q;
	logic signed [W-1:0]       off_x_q, off_y_q, off_z_q;
	trig_load_t                trig_ld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			off_x_q <= '0;
			off_y_q <= '0;
			off_z_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SCALE:    scale_q <= cfg_wdata[SCALE_W-1:0];
				REG_OFFSET_X: off_x_q <= cfg_wdata[W-1:0];
				REG_OFFSET_Y: off_y_q <= cfg_wdata[W-1:0];
				REG_OFFSET_Z: off_z_q <= cfg_wdata[W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Angle writes go straight to the coefficient unit; the angle itself is not kept.
	always_comb begin
		trig_ld.load = 1'b0;
		trig_ld.sel  = ANG_YAW;
		unique case (cfg_addr)
			REG_YAW: begin
				trig_ld.load = cfg_we;
				trig_ld.sel  = ANG_YAW;
			end
			REG_PITCH: begin
				trig_ld.load = cfg_we;
				trig_ld.sel  = ANG_PITCH;
			end
			REG_ROLL: begin
				trig_ld.load = cfg_we;
				trig_ld.sel  = ANG_ROLL;
			end
			default: begin
			end
		endcase
	end

	logic signed [CW-1:0] cos_yaw, sin_yaw, cos_pitch, sin_pitch, cos_roll, sin_roll;

	evt_trig #(
		.ANGLE_BITS (ANGLE_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_trig (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld        (trig_ld),
		.angle     (cfg_wdata[ANGLE_BITS-1:0]),
		.yaw_cos   (cos_yaw),
		.yaw_sin   (sin_yaw),
		.pitch_cos (cos_pitch),
		.pitch_sin (sin_pitch),
		.roll_cos  (cos_roll),
		.roll_sin  (sin_roll)
	);

	// ---------------------------------------------------------------- flow control
	// A stage advances when it is empty or when the stage after it advances.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic adv_1, adv_2, adv_3, adv_4, adv_5, adv_6, adv_7, adv_8;

	assign adv_8 = !vld_s8 || m_tready;
	assign adv_7 = !vld_s7 || adv_8;
	assign adv_6 = !vld_s6 || adv_7;
	assign adv_5 = !vld_s5 || adv_6;
	assign adv_4 = !vld_s4 || adv_5;
	assign adv_3 = !vld_s3 || adv_4;
	assign adv_2 = !vld_s2 || adv_3;
	assign adv_1 = !vld_s1 || adv_2;

	assign s_tready = adv_1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (adv_1) vld_s1 <= s_tvalid;
			if (adv_2) vld_s2 <= vld_s1;
			if (adv_3) vld_s3 <= vld_s2;
			if (adv_4) vld_s4 <= vld_s3;
			if (adv_5) vld_s5 <= vld_s4;
			if (adv_6) vld_s6 <= vld_s5;
			if (adv_7) vld_s7 <= vld_s6;
			if (adv_8) vld_s8 <= vld_s7;
		end
	end

	// ---------------------------------------------------------------- datapath
	logic signed [W-1:0] lx, ly, lz;

	assign lx = s_tdata[W-1:0];
	assign ly = s_tdata[2*W-1:W];
	assign lz = s_tdata[3*W-1:2*W];

	// Stage 1: roll products.
	logic signed [P1W-1:0] lx_cr_s1, ly_sr_s1, lx_sr_s1, ly_cr_s1;
	logic signed [W-1:0]   z_s1;
	// Stage 2: roll sums.
	logic signed [XW-1:0]  x_s2, y_s2;
	logic signed [W-1:0]   z_s2;
	// Stage 3: pitch products.
	logic signed [P3AW-1:0] y_cp_s3, y_sp_s3;
	logic signed [P3BW-1:0] z_sp_s3, z_cp_s3;
	logic signed [XW-1:0]   x_s3;
	// Stage 4: pitch sums.
	logic signed [Y2W-1:0] y2_s4, z2_s4;
	logic signed [XW-1:0]  x_s4;
	// Stage 5: yaw products.
	logic signed [P5AW-1:0] x_cy_s5, x_sy_s5;
	logic signed [P5BW-1:0] z2_sy_s5, z2_cy_s5;
	logic signed [Y2W-1:0]  y2_s5;
	// Stage 6: yaw sums.
	logic signed [VW-1:0] x3_s6, y2_s6, z3_s6;
	// Stage 7: scale products.
	logic signed [P7W-1:0] x_scl_s7, y_scl_s7, z_scl_s7;
	// Stage 8: offset and saturation, the output register.
	logic [W-1:0] world_x_s8, world_y_s8, world_z_s8;

	// Floor of each product: the bits above the fraction. The rotation floors never need
	// more than one bit beyond their vector operand because |coefficient| <= 1.0.
	logic signed [W:0]    fl_lx_cr, fl_ly_sr, fl_lx_sr, fl_ly_cr;
	logic signed [XW:0]   fl_y_cp, fl_y_sp, fl_x_cy, fl_x_sy;
	logic signed [W:0]    fl_z_sp, fl_z_cp;
	logic signed [Y2W:0]  fl_z2_sy, fl_z2_cy;
	logic signed [FW-1:0] fl_x_scl, fl_y_scl, fl_z_scl;
	logic signed [SW-1:0] sum_x, sum_y, sum_z;

	always_comb begin
		fl_lx_cr = lx_cr_s1[FRAC_BITS +: W+1];
		fl_ly_sr = ly_sr_s1[FRAC_BITS +: W+1];
		fl_lx_sr = lx_sr_s1[FRAC_BITS +: W+1];
		fl_ly_cr = ly_cr_s1[FRAC_BITS +: W+1];
		fl_y_cp  = y_cp_s3[FRAC_BITS +: XW+1];
		fl_y_sp  = y_sp_s3[FRAC_BITS +: XW+1];
		fl_z_sp  = z_sp_s3[FRAC_BITS +: W+1];
		fl_z_cp  = z_cp_s3[FRAC_BITS +: W+1];
		fl_x_cy  = x_cy_s5[FRAC_BITS +: XW+1];
		fl_x_sy  = x_sy_s5[FRAC_BITS +: XW+1];
		fl_z2_sy = z2_sy_s5[FRAC_BITS +: Y2W+1];
		fl_z2_cy = z2_cy_s5[FRAC_BITS +: Y2W+1];
		fl_x_scl = x_scl_s7[P7W-1:FRAC_BITS];
		fl_y_scl = y_scl_s7[P7W-1:FRAC_BITS];
		fl_z_scl = z_scl_s7[P7W-1:FRAC_BITS];
		sum_x    = SW'(off_x_q) + SW'(fl_x_scl);
		sum_y    = SW'(off_y_q) + SW'(fl_y_scl);
		sum_z    = SW'(off_z_q) + SW'(fl_z_scl);
	end

	always_ff @(posedge clk) begin
		if (adv_1) begin
			lx_cr_s1 <= lx * cos_roll;
			ly_sr_s1 <= ly * sin_roll;
			lx_sr_s1 <= lx * sin_roll;
			ly_cr_s1 <= ly * cos_roll;
			z_s1     <= lz;
		end
		if (adv_2) begin
			x_s2 <= XW'(fl_lx_cr) - XW'(fl_ly_sr);
			y_s2 <= XW'(fl_lx_sr) + XW'(fl_ly_cr);
			z_s2 <= z_s1;
		end
		if (adv_3) begin
			y_cp_s3 <= y_s2 * cos_pitch;
			z_sp_s3 <= z_s2 * sin_pitch;
			y_sp_s3 <= y_s2 * sin_pitch;
			z_cp_s3 <= z_s2 * cos_pitch;
			x_s3    <= x_s2;
		end
		if (adv_4) begin
			y2_s4 <= Y2W'(fl_y_cp) - Y2W'(fl_z_sp);
			z2_s4 <= Y2W'(fl_y_sp) + Y2W'(fl_z_cp);
			x_s4  <= x_s3;
		end
		if (adv_5) begin
			x_cy_s5  <= x_s4 * cos_yaw;
			z2_sy_s5 <= z2_s4 * sin_yaw;
			z2_cy_s5 <= z2_s4 * cos_yaw;
			x_sy_s5  <= x_s4 * sin_yaw;
			y2_s5    <= y2_s4;
		end
		if (adv_6) begin
			x3_s6 <= VW'(fl_x_cy) + VW'(fl_z2_sy);
			z3_s6 <= VW'(fl_z2_cy) - VW'(fl_x_sy);
			y2_s6 <= VW'(y2_s5);
		end
		if (adv_7) begin
			x_scl_s7 <= x3_s6 * $signed({1'b0, scale_q});
			y_scl_s7 <= y2_s6 * $signed({1'b0, scale_q});
			z_scl_s7 <= z3_s6 * $signed({1'b0, scale_q});
		end
		if (adv_8) begin
			world_x_s8 <= sat_w(sum_x);
			world_y_s8 <= sat_w(sum_y);
			world_z_s8 <= sat_w(sum_z);
		end
	end

	assign m_tvalid = vld_s8;
	assign m_tdata  = {world_z_s8, world_y_s8, world_x_s8};

	// ---------------------------------------------------------------- assertions
	// An empty first stage must always take a beat.
	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> s_tready)
		else $error("input refused while the first stage is empty");

	// An accepted beat lands in the first stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_s1)
		else $error("accepted beat lost at the first stage");

	// A stalled middle stage keeps its beat.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && !adv_4) |=> vld_s4)
		else $error("stalled stage dropped its beat");

	// A beat leaving stage seven reaches the output register.
	a_reach_output: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s7 && adv_7) |=> m_tvalid)
		else $error("beat lost before the output register");

endmodule
